FILE: rtl/core/lspa_pkg.sv
// Package: payload types, fixed constants, state type and scale helper for the pulse animator.
`timescale 1ns / 1ps

package lspa_pkg;

    localparam int LVL_W = 8;
    localparam int IDX_W = 5;
    localparam int THR_W = 11;
    localparam int AMP_W = 13;

    localparam logic [LVL_W-1:0] DECAY_FACTOR = 8'hF0;
    localparam logic [LVL_W-1:0] TAPER_STEP   = 8'h11;
    localparam logic [LVL_W-1:0] TAPER_TOP    = 8'hFF;
    localparam logic [LVL_W-1:0] STEP_MIN     = 8'd32;
    localparam logic [4:0]       RATE_SCALE   = 5'd16;
    localparam logic [AMP_W-1:0] AMP_FULL     = 13'd4096;
    localparam logic [AMP_W-1:0] AMP_ROUND    = 13'd2048;

    typedef struct packed {
        logic [THR_W-1:0] throttle;
        logic [LVL_W-1:0] brightness;
        logic             clear_first;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_index;
        logic [LVL_W-1:0] pixel_level;
        logic             last_pixel;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAPER,
        S_ROTATE
    } t_state;

    // (a*b)>>8 on 8-bit operands
    function automatic logic [LVL_W-1:0] f_scale8(input logic [LVL_W-1:0] a,
                                                  input logic [LVL_W-1:0] b);
        logic [2*LVL_W-1:0] prod;
        prod = {{LVL_W{1'b0}}, a} * {{LVL_W{1'b0}}, b};
        return prod[2*LVL_W-1:LVL_W];
    endfunction

endpackage

FILE: rtl/core/lspa_cell.sv
// One level store entry of the rotating chain.
`timescale 1ns / 1ps

module lspa_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_shift,
    input  logic [lspa_pkg::LVL_W-1:0] i_next,
    output logic [lspa_pkg::LVL_W-1:0] o_level
);
    import lspa_pkg::*;

    logic [LVL_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_shift) begin
            r_level <= i_next;
        end
    end

    assign o_level = r_level;

endmodule

FILE: rtl/core/lspa_pulse.sv
// Pulse amplitude and position update, wrap at strip end, and taper amounts.
`timescale 1ns / 1ps

module lspa_pulse #(
    parameter int STRIP_LENGTH     = 17,
    parameter int PULSE_HALF_WIDTH = 2,
    parameter int HEAD_W           = 5
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_load,
    input  logic [lspa_pkg::THR_W-1:0]               i_throttle,
    input  logic                                     i_taper,
    output logic [HEAD_W-1:0]                        o_center,
    output logic [PULSE_HALF_WIDTH:0][lspa_pkg::LVL_W-1:0] o_add
);
    import lspa_pkg::*;

    localparam int POS_MAX = (STRIP_LENGTH + 1) * 256 + 160;
    localparam int POS_W   = $clog2(POS_MAX + 1);

    logic [AMP_W-1:0]  r_amp, n_amp;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [HEAD_W-1:0] r_center, n_center;
    logic [PULSE_HALF_WIDTH:0][LVL_W-1:0] r_add;

    logic [15:0]      w_thr_scaled;
    logic [LVL_W-1:0] w_step;
    logic [AMP_W-1:0] w_amp_sum, w_amp1;
    logic             w_full;
    logic [POS_W-1:0] w_pos1;
    logic [POS_W:0]   w_pos_rnd;
    logic             w_wrap;

    always_comb begin
        w_thr_scaled = 16'(i_throttle) * 16'(RATE_SCALE) + 16'd128;
        w_step       = STEP_MIN + LVL_W'(w_thr_scaled >> 8);
        w_amp_sum    = r_amp + AMP_W'(w_step);
        w_full       = (w_amp_sum >= AMP_FULL);
        w_amp1       = w_full ? AMP_FULL : w_amp_sum;
        w_pos1       = w_full ? (r_pos + POS_W'(w_step)) : r_pos;
        w_pos_rnd    = {1'b0, w_pos1} + (POS_W + 1)'(128);
        w_wrap       = ((w_pos_rnd >> 8) > (POS_W + 1)'(STRIP_LENGTH));
        n_amp        = w_wrap ? '0 : w_amp1;
        n_pos        = w_wrap ? '0 : w_pos1;
        n_center     = w_wrap ? HEAD_W'(PULSE_HALF_WIDTH)
                              : HEAD_W'(w_pos_rnd >> 8) + HEAD_W'(PULSE_HALF_WIDTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp <= '0;
            r_pos <= '0;
        end else if (i_load) begin
            r_amp <= n_amp;
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_center <= n_center;
        end
    end

    // taper i: ((0xFF - 0x11*i) * amp + round) >> 12, constant multiplies
    for (genvar g = 0; g <= PULSE_HALF_WIDTH; g++) begin : g_taper
        logic [20:0] w_prod;
        assign w_prod = 21'(TAPER_TOP - LVL_W'(TAPER_STEP * g)) * 21'(r_amp)
                      + 21'(AMP_ROUND);
        always_ff @(posedge i_clk) begin
            if (i_taper) begin
                r_add[g] <= w_prod[19:12];
            end
        end
    end

    assign o_center = r_center;
    assign o_add    = r_add;

endmodule

FILE: rtl/core/lspa_head.sv
// Head of the chain: clear, decay, saturating pulse deposit and pixel output.
`timescale 1ns / 1ps

module lspa_head #(
    parameter int STRIP_LENGTH     = 17,
    parameter int PULSE_HALF_WIDTH = 2,
    parameter int HEAD_W           = 5
) (
    input  logic [HEAD_W-1:0]                              i_head,
    input  logic [HEAD_W-1:0]                              i_center,
    input  logic                                           i_clear,
    input  logic [PULSE_HALF_WIDTH:0][lspa_pkg::LVL_W-1:0] i_tap,
    input  logic [PULSE_HALF_WIDTH:0][lspa_pkg::LVL_W-1:0] i_add,
    input  logic [lspa_pkg::LVL_W-1:0]                     i_brightness,
    output logic [lspa_pkg::LVL_W-1:0]                     o_level,
    output logic                                           o_emit,
    output lspa_pkg::t_out_item                            o_pix
);
    import lspa_pkg::*;

    localparam int STORE_DEPTH = STRIP_LENGTH + 2 * PULSE_HALF_WIDTH + 1;
    localparam int TOP_IDX     = STORE_DEPTH - 1;

    logic [LVL_W-1:0] w_src, w_add, w_raw, w_dec;
    logic             w_top;
    logic [LVL_W:0]   w_sum;
    logic [HEAD_W:0]  w_head_x, w_ctr_x;

    always_comb begin
        w_head_x = {1'b0, i_head};
        w_ctr_x  = {1'b0, i_center};
        w_src    = i_tap[0];
        w_add    = '0;
        w_top    = (w_head_x == (HEAD_W + 1)'(TOP_IDX));
        for (int i = 0; i <= PULSE_HALF_WIDTH; i++) begin
            // forward side takes its own entry
            if (w_head_x == w_ctr_x + (HEAD_W + 1)'(i)) begin
                w_add = i_add[i];
            end
            // mirror side copies the forward entry, 2*i cells ahead
            if (i != 0 && w_head_x + (HEAD_W + 1)'(i) == w_ctr_x) begin
                w_src = i_tap[i];
                w_add = i_add[i];
                w_top = (w_ctr_x + (HEAD_W + 1)'(i) == (HEAD_W + 1)'(TOP_IDX));
            end
        end
        w_raw   = i_clear ? '0 : w_src;
        // topmost entry is never decayed
        w_dec   = w_top ? w_raw : f_scale8(w_raw, DECAY_FACTOR);
        w_sum   = {1'b0, w_dec} + {1'b0, w_add};
        o_level = w_sum[LVL_W] ? {LVL_W{1'b1}} : w_sum[LVL_W-1:0];

        o_emit  = (w_head_x >= (HEAD_W + 1)'(PULSE_HALF_WIDTH))
               && (w_head_x < (HEAD_W + 1)'(PULSE_HALF_WIDTH + STRIP_LENGTH));
        o_pix.pixel_index = IDX_W'(w_head_x - (HEAD_W + 1)'(PULSE_HALF_WIDTH));
        o_pix.pixel_level = f_scale8(o_level, i_brightness);
        o_pix.last_pixel  =
            (w_head_x == (HEAD_W + 1)'(PULSE_HALF_WIDTH + STRIP_LENGTH - 1));
    end

endmodule

FILE: rtl/core/led_strip_pulse_animator_top.sv
// Top level: LED wing strip pulse animator built as a rotating chain of level cells.
`timescale 1ns / 1ps

// Channel   Direction  Signals                              Payload
// in        sink       i_in_valid / o_in_ready / i_in_data  t_in_item (throttle, brightness,
//                                                           clear_first)
// out       source     o_out_valid / i_out_ready / o_out_data
//                                                           t_out_item (pixel_index,
//                                                           pixel_level, last_pixel)
//
// Sequence: a tick is accepted in the idle state, the taper amounts are registered in the
//   taper state, then the cell ring rotates once past the head unit, one step per store
//   entry, and ready returns once the rotation ends.
// Each pixel leaves as its entry passes the head.
// Output stalls freeze the ring only on cycles that emit a pixel; the output register
//   lets the ring keep moving while one pixel waits.
// Reset (synchronous, active low) zeroes the store cells, amplitude and position.

module led_strip_pulse_animator_top #(
    parameter int STRIP_LENGTH     = 17,
    parameter int PULSE_HALF_WIDTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lspa_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lspa_pkg::t_out_item o_out_data
);
    import lspa_pkg::*;

    localparam int STORE_DEPTH = STRIP_LENGTH + 2 * PULSE_HALF_WIDTH + 1;
    localparam int HEAD_W      = $clog2(STORE_DEPTH);

    t_state r_state, n_state;

    logic [HEAD_W-1:0] r_head, n_head;
    logic [LVL_W-1:0]  r_bright;
    logic              r_clear;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_data;

    logic              w_accept, w_taper, w_step, w_out_free;
    logic [HEAD_W-1:0] w_center;
    logic [PULSE_HALF_WIDTH:0][LVL_W-1:0] w_add, w_tap;
    logic [LVL_W-1:0]  w_cell [STORE_DEPTH];
    logic [LVL_W-1:0]  w_new_level;
    logic              w_emit;
    t_out_item         w_pix;

    // ------------------------------------------------------------------
    // Control: idle -> taper amounts -> one full ring rotation
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        o_in_ready  = 1'b0;
        w_taper     = 1'b0;
        w_out_free  = !r_out_valid || i_out_ready;
        w_step      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_TAPER;
                end
            end
            S_TAPER: begin
                w_taper = 1'b1;
                n_state = S_ROTATE;
            end
            S_ROTATE: begin
                // only pixel-emitting steps wait on the output register
                w_step = !w_emit || w_out_free;
                if (w_step) begin
                    if (r_head == HEAD_W'(STORE_DEPTH - 1)) begin
                        n_head  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_head = r_head + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        w_accept = i_in_valid && o_in_ready;

        if (w_step && w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // per-tick operands
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bright <= i_in_data.brightness;
            r_clear  <= i_in_data.clear_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out_data <= w_pix;
        end
    end

    // ------------------------------------------------------------------
    // Pulse state: amplitude ramp, travel, wrap, taper amounts
    // ------------------------------------------------------------------
    lspa_pulse #(
        .STRIP_LENGTH     (STRIP_LENGTH),
        .PULSE_HALF_WIDTH (PULSE_HALF_WIDTH),
        .HEAD_W           (HEAD_W)
    ) u_pulse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_throttle (i_in_data.throttle),
        .i_taper    (w_taper),
        .o_center   (w_center),
        .o_add      (w_add)
    );

    // ------------------------------------------------------------------
    // Cell ring: cell k holds entry r_head+k; the head result re-enters at the tail
    // ------------------------------------------------------------------
    for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
        logic [LVL_W-1:0] w_next;
        if (k == STORE_DEPTH - 1) begin : g_tail
            assign w_next = w_new_level;
        end else begin : g_body
            assign w_next = w_cell[k + 1];
        end
        lspa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_step),
            .i_next  (w_next),
            .o_level (w_cell[k])
        );
    end

    // mirror entry center-i pulls from entry center+i, 2*i cells ahead
    for (genvar t = 0; t <= PULSE_HALF_WIDTH; t++) begin : g_tap
        assign w_tap[t] = w_cell[2 * t];
    end

    lspa_head #(
        .STRIP_LENGTH     (STRIP_LENGTH),
        .PULSE_HALF_WIDTH (PULSE_HALF_WIDTH),
        .HEAD_W           (HEAD_W)
    ) u_head (
        .i_head       (r_head),
        .i_center     (w_center),
        .i_clear      (r_clear),
        .i_tap        (w_tap),
        .i_add        (w_add),
        .i_brightness (r_bright),
        .o_level      (w_new_level),
        .o_emit       (w_emit),
        .o_pix        (w_pix)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the LED strip pulse animator: tick driver, pixel monitor, predictor.
`timescale 1ns / 1ps

module tb;
    import lspa_pkg::*;

    localparam int STRIP_LEN   = 17;
    localparam int HALF_W      = 2;
    localparam int STORE_N     = STRIP_LEN + 2 * HALF_W + 1;
    localparam int DECAY_N     = STRIP_LEN + 2 * HALF_W;

    // Animation arithmetic, kept local so a wrong package constant still shows up
    localparam int unsigned FADE       = 240;
    localparam int unsigned TAPER_PEAK = 255;
    localparam int unsigned TAPER_DROP = 17;
    localparam int unsigned STEP_FLOOR = 32;
    localparam int unsigned RATE_MUL   = 16;
    localparam int unsigned AMP_MAX    = 4096;
    localparam int unsigned AMP_HALF   = 2048;
    localparam int unsigned LVL_MAX    = 255;

    localparam int N_RANDOM    = 150;
    localparam int RESET_LEN   = 9;
    localparam int TAIL_CYCLES = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Ticks still to be sent, and pixels predicted but not yet seen
    t_in_item  tick_q[$];
    t_out_item pixel_expect_q[$];

    // Predictor state: level store, 13-bit pulse amplitude, 5.8 pulse position
    logic [7:0]  level_mem [STORE_N];
    int unsigned pulse_amp;
    int unsigned pulse_pos;

    int      n_ticks   = 0;
    int      n_issued  = 0;
    int      n_errors  = 0;
    int      n_shown   = 0;
    longint  n_cycles  = 0;

    led_strip_pulse_animator_top #(
        .STRIP_LENGTH     (STRIP_LEN),
        .PULSE_HALF_WIDTH (HALF_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Stall pattern by thirds of the run: sender light / receiver heavy,
    // then swapped, then both streaming with no gaps.
    function automatic int idle_pct(input bit sender);
        int phase;
        phase = (n_ticks == 0) ? 0 : (n_issued * 3) / n_ticks;
        case (phase)
            0: begin
                return sender ? 21 : 64;
            end
            1: begin
                return sender ? 64 : 21;
            end
            default: begin
                return 0;
            end
        endcase
    endfunction

    // Points where the sender holds off until the pipe has fully drained
    function automatic bit drain_point(input int issued);
        return issued == 10 || issued == n_ticks / 3 || issued == (2 * n_ticks) / 3;
    endfunction

    // One animation tick: clear, decay, ramp, travel, wrap, deposit, then the
    // brightness-scaled pixels that the tick produces.
    task automatic animate_tick(input t_in_item t);
        int unsigned step;
        int unsigned idx;
        int unsigned center;
        int unsigned add;
        int unsigned v;
        t_out_item   px;
        if (t.clear_first) begin
            foreach (level_mem[k]) level_mem[k] = '0;
        end
        // topmost store entry is left out of the decay
        for (int k = 0; k < DECAY_N; k++) begin
            level_mem[k] = 8'((32'(level_mem[k]) * FADE) >> 8);
        end
        step = STEP_FLOOR + ((32'(t.throttle) * RATE_MUL + 128) >> 8);
        pulse_amp += step;
        // position only moves once the amplitude has saturated
        if (pulse_amp >= AMP_MAX) begin
            pulse_amp = AMP_MAX;
            pulse_pos += step;
        end
        idx = (pulse_pos + 128) >> 8;
        if (idx > STRIP_LEN) begin
            idx       = 0;
            pulse_pos = 0;
            pulse_amp = 0;
        end
        center = idx + HALF_W;
        // forward side saturates, mirror side takes the same value
        for (int k = 0; k <= HALF_W; k++) begin
            add = ((TAPER_PEAK - TAPER_DROP * k) * pulse_amp + AMP_HALF) >> 12;
            v   = 32'(level_mem[center + k]) + add;
            if (v > LVL_MAX) v = LVL_MAX;
            level_mem[center + k] = 8'(v);
            level_mem[center - k] = 8'(v);
        end
        for (int k = 0; k < STRIP_LEN; k++) begin
            px.pixel_index = 5'(k);
            px.pixel_level = 8'((32'(level_mem[HALF_W + k]) * 32'(t.brightness)) >> 8);
            px.last_pixel  = (k == STRIP_LEN - 1);
            pixel_expect_q.push_back(px);
        end
    endtask

    task automatic flag_field(input string what, input int unsigned exp_v,
                              input int unsigned act_v);
        n_errors++;
        if (n_shown < MAX_SHOWN) begin
            n_shown++;
            $display("[%0t] pixel %s mismatch: expected %0d, got %0d", $realtime, what,
                     exp_v, act_v);
        end
    endtask

    task automatic check_pixel(input t_out_item got);
        t_out_item exp_px;
        if (pixel_expect_q.size() == 0) begin
            n_errors++;
            if (n_shown < MAX_SHOWN) begin
                n_shown++;
                $display("[%0t] unexpected pixel transfer: index %0d level %0d last %0d",
                         $realtime, got.pixel_index, got.pixel_level, got.last_pixel);
            end
        end else begin
            exp_px = pixel_expect_q.pop_front();
            if (got.pixel_index !== exp_px.pixel_index)
                flag_field("index", exp_px.pixel_index, got.pixel_index);
            if (got.pixel_level !== exp_px.pixel_level)
                flag_field("level", exp_px.pixel_level, got.pixel_level);
            if (got.last_pixel !== exp_px.last_pixel)
                flag_field("last", exp_px.last_pixel, got.last_pixel);
        end
    endtask

    // Driver: predicts on each accepted tick, then offers the next one.
    // Valid is only reconsidered when it is low or its transfer just happened.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                animate_tick(i_in_data);
            end
            if (!i_in_valid || o_in_ready) begin
                if (tick_q.size() != 0
                        && !(drain_point(n_issued) && pixel_expect_q.size() != 0)
                        && $urandom_range(99) >= idle_pct(1'b1)) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= tick_q.pop_front();
                    n_issued = n_issued + 1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each pixel transfer and throttles ready at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                check_pixel(o_out_data);
            end
            i_out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("led_strip_pulse_animator_top verification failed");
            $finish;
        end
    end

    function automatic t_in_item mk_tick(input int unsigned thr, input int unsigned bri,
                                         input bit clr);
        t_in_item t;
        t.throttle    = 11'(thr);
        t.brightness  = 8'(bri);
        t.clear_first = clr;
        return t;
    endfunction

    initial begin
        t_in_item t;
        bit       racing;
        int       run_left;
        racing   = 1'b0;
        run_left = 0;
        foreach (level_mem[k]) level_mem[k] = '0;
        pulse_amp = 0;
        pulse_pos = 0;

        // Directed: field extremes, clears on a lightly filled and a filled store,
        // alternating bit patterns, then a full-throttle run that ramps the amplitude.
        tick_q.push_back(mk_tick(0, 255, 1'b0));
        tick_q.push_back(mk_tick(2047, 255, 1'b0));
        tick_q.push_back(mk_tick(2047, 0, 1'b0));
        tick_q.push_back(mk_tick(0, 0, 1'b1));
        tick_q.push_back(mk_tick(11'h555, 8'hAA, 1'b0));
        tick_q.push_back(mk_tick(11'h2AA, 8'h55, 1'b1));
        tick_q.push_back(mk_tick(1024, 128, 1'b0));
        tick_q.push_back(mk_tick(7, 1, 1'b0));
        for (int n = 0; n < 14; n++) begin
            tick_q.push_back(mk_tick(2047, (n * 37 + 19) & 8'hFF, 1'b0));
        end
        tick_q.push_back(mk_tick(2047, 255, 1'b1));

        // Random: mostly fast runs so the pulse saturates, travels and wraps,
        // mixed with stretches of arbitrary throttle; clears stay rare.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (run_left == 0) begin
                racing   = ($urandom_range(99) < 65);
                run_left = $urandom_range(30, 5);
            end
            run_left--;
            t.throttle    = racing ? 11'($urandom_range(2047, 1700)) : 11'($urandom_range(2047));
            t.brightness  = 8'($urandom);
            t.clear_first = ($urandom_range(24) == 0);
            tick_q.push_back(t);
        end
        n_ticks = tick_q.size();

        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (tick_q.size() != 0 || i_in_valid || pixel_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pixel_expect_q.size() != 0) begin
            n_errors += pixel_expect_q.size();
            $display("%0d predicted pixels never arrived", pixel_expect_q.size());
        end
        if (n_errors == 0) begin
            $display("led_strip_pulse_animator_top verification clean");
        end else begin
            $display("led_strip_pulse_animator_top verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/lspa_pkg.sv
rtl/core/lspa_cell.sv
rtl/core/lspa_pulse.sv
rtl/core/lspa_head.sv
rtl/core/led_strip_pulse_animator_top.sv
dv/tb.sv
